// ===== rtl/core/rfap_pkg.sv =====
// Shared types, byte codes and decimal scale table for the rangefinder frame parser.
package rfap_pkg;

  localparam int VALUE_W = 30;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  localparam logic [7:0] CHAR_HDR_START  = 8'h44;
  localparam logic [7:0] CHAR_HDR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_FRAME_END  = 8'h6D;
  localparam logic [7:0] CHAR_POINT      = 8'h2E;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;

  localparam int FRAC_W  = 3;
  localparam int SCALE_W = 20;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_EQUALS  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  typedef struct packed {
    logic clear;
    logic push;
  } acc_ctrl_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] n);
    logic [SCALE_W-1:0] r;
    case (n)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      3'd6:    r = 20'd1000000;
      default: r = 20'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rangefinder_ascii_frame_parser.sv =====
// Top level of the rangefinder ASCII frame parser.
// Takes one serial byte per cycle unless in_stall is high, hunts for the "D="
// header, folds up to MAX_PAYLOAD payload bytes into a running decimal value
// as they arrive and, on the closing 'm', emits the newest reading in units
// of 10^-FRACTION_DIGITS together with the two readings before it. The result
// leaves through an output register backed by a one-entry skid stage, so input
// is stalled only while both are full.
module rangefinder_ascii_frame_parser #(
  parameter int MAX_PAYLOAD     = 6,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfap_pkg::VALUE_W-1:0]  distance_now,
  output logic [rfap_pkg::VALUE_W-1:0]  distance_prev,
  output logic [rfap_pkg::VALUE_W-1:0]  distance_prev2
);

  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int PROD_W = rfap_pkg::VALUE_W + rfap_pkg::SCALE_W;

  rfap_pkg::phase_t phase;
  rfap_pkg::phase_t phase_next;
  logic [CNT_W-1:0] payload_count;
  logic [CNT_W-1:0] payload_count_next;

  logic [rfap_pkg::VALUE_W-1:0] reading_latest;
  logic [rfap_pkg::VALUE_W-1:0] reading_older;
  logic [rfap_pkg::VALUE_W-1:0] reading_oldest;

  logic skid_valid;
  logic [rfap_pkg::VALUE_W-1:0] skid_now;
  logic [rfap_pkg::VALUE_W-1:0] skid_prev;
  logic [rfap_pkg::VALUE_W-1:0] skid_prev2;

  logic accept;
  logic res_fire;
  rfap_pkg::acc_ctrl_t acc_ctrl;
  logic [rfap_pkg::VALUE_W:0] acc;
  logic [rfap_pkg::FRAC_W-1:0] frac;
  logic [PROD_W-1:0] prod;
  logic [rfap_pkg::VALUE_W-1:0] scaled;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    acc_ctrl           = '0;
    res_fire           = 1'b0;
    if (accept) begin
      case (phase)
        rfap_pkg::PH_EQUALS: begin
          if (rx_byte == rfap_pkg::CHAR_HDR_EQUALS) begin
            phase_next         = rfap_pkg::PH_COLLECT;
            payload_count_next = '0;
            acc_ctrl.clear     = 1'b1;
          end else begin
            phase_next = rfap_pkg::PH_HUNT;
          end
        end
        rfap_pkg::PH_COLLECT: begin
          if (rx_byte == rfap_pkg::CHAR_FRAME_END) begin
            res_fire           = 1'b1;
            phase_next         = rfap_pkg::PH_HUNT;
            payload_count_next = '0;
          end else if (payload_count >= CNT_W'(MAX_PAYLOAD)) begin
            phase_next         = rfap_pkg::PH_HUNT;
            payload_count_next = '0;
          end else begin
            acc_ctrl.push      = 1'b1;
            payload_count_next = payload_count + CNT_W'(1);
          end
        end
        default: begin
          phase_next = (rx_byte == rfap_pkg::CHAR_HDR_START) ? rfap_pkg::PH_EQUALS
                                                             : rfap_pkg::PH_HUNT;
        end
      endcase
    end
  end

  rfap_value_acc #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_acc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (acc_ctrl),
    .rx_byte (rx_byte),
    .acc     (acc),
    .frac    (frac)
  );

  always_comb begin
    prod = {{rfap_pkg::SCALE_W{1'b0}}, acc[rfap_pkg::VALUE_W-1:0]} *
           {{rfap_pkg::VALUE_W{1'b0}},
            rfap_pkg::pow10(rfap_pkg::FRAC_W'(FRACTION_DIGITS) - frac)};
    if (acc[rfap_pkg::VALUE_W] ||
        prod > {{rfap_pkg::SCALE_W{1'b0}}, rfap_pkg::VALUE_MAX}) begin
      scaled = rfap_pkg::VALUE_MAX;
    end else begin
      scaled = prod[rfap_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rfap_pkg::PH_HUNT;
      payload_count  <= '0;
      reading_latest <= '0;
      reading_older  <= '0;
      reading_oldest <= '0;
    end else begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      if (res_fire) begin
        reading_latest <= scaled;
        reading_older  <= reading_latest;
        reading_oldest <= reading_older;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        distance_now   <= skid_now;
        distance_prev  <= skid_prev;
        distance_prev2 <= skid_prev2;
      end else if (res_fire) begin
        distance_now   <= scaled;
        distance_prev  <= reading_latest;
        distance_prev2 <= reading_older;
      end
    end else if (res_fire) begin
      skid_now   <= scaled;
      skid_prev  <= reading_latest;
      skid_prev2 <= reading_older;
    end
  end

endmodule

// ===== rtl/core/rfap_value_acc.sv =====
// Running decimal accumulator: folds payload bytes into a saturating integer and fraction-digit count.
module rfap_value_acc #(
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rfap_pkg::acc_ctrl_t                ctrl,
  input  logic [7:0]                         rx_byte,
  output logic [rfap_pkg::VALUE_W:0]         acc,
  output logic [rfap_pkg::FRAC_W-1:0]        frac
);

  localparam int STEP_W = rfap_pkg::VALUE_W + 5;

  logic skipping;
  logic seen_point;
  logic stopped;

  logic is_digit;
  logic is_point;
  logic is_blank;
  logic [STEP_W-1:0] step_raw;
  logic [rfap_pkg::VALUE_W:0] acc_step;

  assign is_digit = (rx_byte >= rfap_pkg::CHAR_ZERO) && (rx_byte <= rfap_pkg::CHAR_NINE);
  assign is_point = (rx_byte == rfap_pkg::CHAR_POINT);
  assign is_blank = (rx_byte == rfap_pkg::CHAR_SPACE) ||
                    ((rx_byte >= rfap_pkg::CHAR_TAB) && (rx_byte <= rfap_pkg::CHAR_CR));

  always_comb begin
    step_raw = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
               {{(STEP_W-4){1'b0}}, rx_byte[3:0]};
    if (step_raw > {{(STEP_W-rfap_pkg::VALUE_W){1'b0}}, rfap_pkg::VALUE_MAX}) begin
      acc_step = {1'b1, {rfap_pkg::VALUE_W{1'b0}}};
    end else begin
      acc_step = step_raw[rfap_pkg::VALUE_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc        <= '0;
      frac       <= '0;
      skipping   <= 1'b1;
      seen_point <= 1'b0;
      stopped    <= 1'b0;
    end else if (ctrl.push && !stopped && !(skipping && is_blank)) begin
      skipping <= 1'b0;
      if (is_digit) begin
        if (!seen_point) begin
          acc <= acc_step;
        end else if (frac < rfap_pkg::FRAC_W'(FRACTION_DIGITS)) begin
          acc  <= acc_step;
          frac <= frac + rfap_pkg::FRAC_W'(1);
        end
      end else if (is_point && !seen_point) begin
        seen_point <= 1'b1;
      end else begin
        stopped <= 1'b1;
      end
    end
  end

endmodule
